// ===== hw/rtl/dcc_pkg.sv =====
// dcc_pkg: constants, inter-stage payload type and calendar tables for the
// day-count to calendar-field converter. Used by dcc_front, dcc_back and the top level.
// No dependencies.
package dcc_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_TWELVE_HOUR = 8'd0;
    localparam logic [7:0] CFG_SUBST_REL   = 8'd1;

    // Relative-day class codes
    localparam logic [2:0] REL_ABSOLUTE  = 3'd0;
    localparam logic [2:0] REL_YESTERDAY = 3'd1;
    localparam logic [2:0] REL_TODAY     = 3'd2;
    localparam logic [2:0] REL_TOMORROW  = 3'd3;
    localparam logic [2:0] REL_FUTURE    = 3'd4;
    localparam logic [2:0] REL_WEEKDAY   = 3'd5;

    // Moduli
    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;  // four years
    localparam logic [10:0] MINS_PER_DAY   = 11'd1440;
    localparam logic [11:0] TICKS_PER_MIN  = 12'd3000;
    localparam logic [8:0]  BASE_YEAR      = 9'd78;

    // Reciprocals. The 2^-24 ones round down, so the quotient is exact or
    // one short; a compare-subtract fixes it. The 2^-16 ones round up and
    // are exact over the reduced ranges (0..1440 and 0..3000).
    localparam logic [13:0] DAYS_RECIP = 14'd11483;  // 2^24 / 1461
    localparam logic [13:0] MINS_RECIP = 14'd11650;  // 2^24 / 1440
    localparam logic [13:0] TICK_RECIP = 14'd5592;   // 2^24 / 3000
    localparam logic [10:0] HOUR_RECIP = 11'd1093;   // 2^16 / 60
    localparam logic [10:0] SEC_RECIP  = 11'd1311;   // 2^16 / 50

    // Payload from the reduction half to the calendar half
    typedef struct packed {
        logic [5:0]  cycle_q;   // whole four-year cycles
        logic [10:0] cycle_r;   // day within cycle, 0..1460
        logic [2:0]  wday;
        logic [2:0]  rel;
        logic [10:0] mins;      // 0..1440
        logic [11:0] ticks;     // 0..3000
    } dcc_mid_t;

    // Zero-based day of year on which month idx (0 = January) starts
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && idx >= 4'd2)
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== hw/rtl/dcc_front.sv =====
// dcc_front: stages 1-3. Reciprocal reductions of days, minutes and ticks,
// weekday and relative-day class. Depends on dcc_pkg.
module dcc_front
    import dcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] day_count,
    input  logic [15:0] minute_of_day,
    input  logic [15:0] tick_count,
    input  logic [15:0] today_count,
    input  logic        subst_rel,
    output logic        mid_valid,
    input  logic        mid_ready,
    output dcc_mid_t    mid
);

    typedef struct packed {
        logic [15:0] days;
        logic [15:0] mins;
        logic [15:0] ticks;
        logic [29:0] pday;
        logic [29:0] pmin;
        logic [29:0] ptick;
        logic        mins_big;
        logic        ticks_big;
        logic [2:0]  wday;
        logic [2:0]  rel;
    } s1_t;

    typedef struct packed {
        logic [5:0]  cycle_q;
        logic [11:0] cycle_r;   // may still be >= 1461
        logic [11:0] min_r;     // may still be >= 1440
        logic [12:0] tick_r;    // may still be >= 3000
        logic [10:0] mins;
        logic [11:0] ticks;
        logic        mins_big;
        logic        ticks_big;
        logic [2:0]  wday;
        logic [2:0]  rel;
    } s2_t;

    logic     v1_reg, v2_reg, v3_reg;
    logic     ready1, ready2, ready3;
    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    dcc_mid_t s3_reg, s3_next;

    logic [5:0]         chunk_sum;
    logic [3:0]         fold;
    logic signed [16:0] diff;
    logic [5:0]         q_day, q_min;
    logic [4:0]         q_tick;
    logic [15:0]        r_day, r_min, r_tick;

    assign ready3   = !v3_reg || mid_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // Stage 1: products, weekday by octal digit sum (8 = 1 mod 7), day difference
    always_comb
    begin
        chunk_sum = 6'(day_count[2:0]) + 6'(day_count[5:3]) + 6'(day_count[8:6])
                  + 6'(day_count[11:9]) + 6'(day_count[14:12]) + 6'(day_count[15]);
        fold      = 4'(chunk_sum[2:0]) + 4'(chunk_sum[5:3]);
        diff      = $signed({1'b0, day_count}) - $signed({1'b0, today_count});

        s1_next.days      = day_count;
        s1_next.mins      = minute_of_day;
        s1_next.ticks     = tick_count;
        s1_next.pday      = 30'(day_count) * 30'(DAYS_RECIP);
        s1_next.pmin      = 30'(minute_of_day) * 30'(MINS_RECIP);
        s1_next.ptick     = 30'(tick_count) * 30'(TICK_RECIP);
        s1_next.mins_big  = minute_of_day > 16'(MINS_PER_DAY);
        s1_next.ticks_big = tick_count > 16'(TICKS_PER_MIN);
        s1_next.wday      = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];

        s1_next.rel = REL_ABSOLUTE;
        if (subst_rel && diff > -17'sd7)
        begin
            if (diff == -17'sd1)
            begin
                s1_next.rel = REL_YESTERDAY;
            end
            else if (diff == 17'sd0)
            begin
                s1_next.rel = REL_TODAY;
            end
            else if (diff == 17'sd1)
            begin
                s1_next.rel = REL_TOMORROW;
            end
            else if (diff > 17'sd1)
            begin
                s1_next.rel = REL_FUTURE;
            end
            else
            begin
                s1_next.rel = REL_WEEKDAY;
            end
        end
    end

    // Stage 2: estimated quotients and raw remainders
    always_comb
    begin
        q_day  = s1_reg.pday[29:24];
        q_min  = s1_reg.pmin[29:24];
        q_tick = s1_reg.ptick[28:24];
        r_day  = s1_reg.days - 16'(17'(q_day) * 17'(DAYS_PER_CYCLE));
        r_min  = s1_reg.mins - 16'(17'(q_min) * 17'(MINS_PER_DAY));
        r_tick = s1_reg.ticks - 16'(17'(q_tick) * 17'(TICKS_PER_MIN));

        s2_next.cycle_q   = q_day;
        s2_next.cycle_r   = r_day[11:0];
        s2_next.min_r     = r_min[11:0];
        s2_next.tick_r    = r_tick[12:0];
        s2_next.mins      = s1_reg.mins[10:0];
        s2_next.ticks     = s1_reg.ticks[11:0];
        s2_next.mins_big  = s1_reg.mins_big;
        s2_next.ticks_big = s1_reg.ticks_big;
        s2_next.wday      = s1_reg.wday;
        s2_next.rel       = s1_reg.rel;
    end

    // Stage 3: one correction step; exact values up to the limit are kept
    always_comb
    begin
        if (s2_reg.cycle_r >= 12'(DAYS_PER_CYCLE))
        begin
            s3_next.cycle_q = s2_reg.cycle_q + 6'd1;
            s3_next.cycle_r = 11'(s2_reg.cycle_r - 12'(DAYS_PER_CYCLE));
        end
        else
        begin
            s3_next.cycle_q = s2_reg.cycle_q;
            s3_next.cycle_r = s2_reg.cycle_r[10:0];
        end

        if (!s2_reg.mins_big)
        begin
            s3_next.mins = s2_reg.mins;
        end
        else if (s2_reg.min_r >= 12'(MINS_PER_DAY))
        begin
            s3_next.mins = 11'(s2_reg.min_r - 12'(MINS_PER_DAY));
        end
        else
        begin
            s3_next.mins = s2_reg.min_r[10:0];
        end

        if (!s2_reg.ticks_big)
        begin
            s3_next.ticks = s2_reg.ticks;
        end
        else if (s2_reg.tick_r >= 13'(TICKS_PER_MIN))
        begin
            s3_next.ticks = 12'(s2_reg.tick_r - 13'(TICKS_PER_MIN));
        end
        else
        begin
            s3_next.ticks = s2_reg.tick_r[11:0];
        end

        s3_next.wday = s2_reg.wday;
        s3_next.rel  = s2_reg.rel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (ready2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (ready3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign mid_valid = v3_reg;
    assign mid       = s3_reg;

    a_reduced_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (s3_reg.cycle_r < DAYS_PER_CYCLE) && (s3_reg.mins <= MINS_PER_DAY)
                   && (s3_reg.ticks <= TICKS_PER_MIN))
        else $error("reduced value out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !mid_ready |=> v3_reg && $stable(s3_reg))
        else $error("stage 3 item lost while stalled");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted item not captured in stage 1");

endmodule

// ===== hw/rtl/dcc_back.sv =====
// dcc_back: stages 4-5. Year within cycle, month search, time split and
// 12-hour mapping; stage 5 is the output register. Depends on dcc_pkg.
module dcc_back
    import dcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mid_valid,
    output logic        mid_ready,
    input  dcc_mid_t    mid,
    input  logic        twelve_hour,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  year_two_digit,
    output logic [3:0]  month_number,
    output logic [4:0]  day_of_month,
    output logic [2:0]  weekday,
    output logic [4:0]  hour_value,
    output logic [5:0]  minute_value,
    output logic [5:0]  second_value,
    output logic        pm_flag,
    output logic [2:0]  relative_class
);

    typedef struct packed {
        logic [8:0]  year;      // 78..257
        logic [8:0]  doy;       // 0..365
        logic        leap;
        logic [10:0] mins;
        logic [20:0] hprod;
        logic [21:0] sprod;
        logic [2:0]  wday;
        logic [2:0]  rel;
    } s4_t;

    logic  v4_reg, v5_reg;
    logic  ready4, ready5;
    s4_t   s4_reg, s4_next;

    logic [6:0] year_reg, year_next;
    logic [3:0] month_reg, month_next;
    logic [4:0] mday_reg, mday_next;
    logic [2:0] wday_reg;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] min_reg, min_next;
    logic [5:0] sec_reg;
    logic       pm_reg, pm_next;
    logic [2:0] rel_reg;

    logic [1:0]  yr_in_cycle;
    logic [10:0] yr_start;
    logic [10:0] doy_full;
    logic [8:0]  mstart;
    logic [4:0]  hr_raw;
    logic [10:0] hr_mins;

    assign ready5    = !v5_reg || out_ready;
    assign ready4    = !v4_reg || ready5;
    assign mid_ready = ready4;

    // Stage 4: year inside the four-year cycle (third year is the leap year)
    always_comb
    begin
        if (mid.cycle_r < 11'd365)
        begin
            yr_in_cycle = 2'd0;
            yr_start    = 11'd0;
        end
        else if (mid.cycle_r < 11'd730)
        begin
            yr_in_cycle = 2'd1;
            yr_start    = 11'd365;
        end
        else if (mid.cycle_r < 11'd1096)
        begin
            yr_in_cycle = 2'd2;
            yr_start    = 11'd730;
        end
        else
        begin
            yr_in_cycle = 2'd3;
            yr_start    = 11'd1096;
        end
        doy_full = mid.cycle_r - yr_start;

        s4_next.year  = BASE_YEAR + 9'({mid.cycle_q, 2'b00}) + 9'(yr_in_cycle);
        s4_next.doy   = doy_full[8:0];
        s4_next.leap  = (s4_next.year[1:0] == 2'b00);
        s4_next.mins  = mid.mins;
        s4_next.hprod = 21'(mid.mins) * 21'(HOUR_RECIP);
        s4_next.sprod = 22'(mid.ticks) * 22'(SEC_RECIP);
        s4_next.wday  = mid.wday;
        s4_next.rel   = mid.rel;
    end

    // Stage 5: month by parallel compares against month starts, then time
    always_comb
    begin
        month_next = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (s4_reg.doy >= month_start(4'(m), s4_reg.leap))
            begin
                month_next = 4'(m);
            end
        end
        mstart     = month_start(month_next, s4_reg.leap);
        mday_next  = 5'(s4_reg.doy - mstart + 9'd1);
        month_next = month_next + 4'd1;

        if (s4_reg.year >= 9'd200)
        begin
            year_next = 7'(s4_reg.year - 9'd200);
        end
        else if (s4_reg.year >= 9'd100)
        begin
            year_next = 7'(s4_reg.year - 9'd100);
        end
        else
        begin
            year_next = s4_reg.year[6:0];
        end

        hr_raw   = s4_reg.hprod[20:16];
        hr_mins  = 11'(hr_raw) * 11'd60;
        min_next = 6'(s4_reg.mins - hr_mins);

        hour_next = hr_raw;
        pm_next   = 1'b0;
        if (twelve_hour)
        begin
            if (hr_raw >= 5'd12)
            begin
                pm_next = 1'b1;
                if (hr_raw > 5'd12)
                begin
                    hour_next = hr_raw - 5'd12;
                end
            end
            else if (hr_raw == 5'd0)
            begin
                hour_next = 5'd12;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready4)
            begin
                v4_reg <= mid_valid;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && mid_valid)
        begin
            s4_reg <= s4_next;
        end
        if (ready5 && v4_reg)
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            mday_reg  <= mday_next;
            wday_reg  <= s4_reg.wday;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= s4_reg.sprod[21:16];
            pm_reg    <= pm_next;
            rel_reg   <= s4_reg.rel;
        end
    end

    assign out_valid      = v5_reg;
    assign year_two_digit = year_reg;
    assign month_number   = month_reg;
    assign day_of_month   = mday_reg;
    assign weekday        = wday_reg;
    assign hour_value     = hour_reg;
    assign minute_value   = min_reg;
    assign second_value   = sec_reg;
    assign pm_flag        = pm_reg;
    assign relative_class = rel_reg;

    a_stage4_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !ready4 |=> v4_reg && $stable(s4_reg))
        else $error("stage 4 item lost while stalled");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_number >= 4'd1) && (month_number <= 4'd12)
                      && (day_of_month >= 5'd1) && (year_two_digit <= 7'd99))
        else $error("date field out of range");

    a_twelve_hour: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && twelve_hour |-> (hour_value >= 5'd1) && (hour_value <= 5'd12))
        else $error("12-hour value out of range");

    a_pm_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !twelve_hour |-> !pm_flag)
        else $error("pm flag set in 24-hour mode");

endmodule

// ===== hw/rtl/day_count_to_calendar_fields_core.sv =====
// Top level of the day-count to calendar-field converter: configuration
// registers and the two pipeline halves. Depends on dcc_pkg, dcc_front, dcc_back.
//
// Turns a timestamp (days since 1 January 1978, a Sunday; minutes past
// midnight; 50 Hz ticks in the minute) into two-digit year, month, day of
// month, weekday, hour, minute, second, a PM flag and a relative-day class
// against today_count. Leap years fall every fourth year with no century
// exception. Minutes above 1440 and ticks above 3000 are reduced modulo
// 1440 and 3000; exactly 1440 gives hour 24 and exactly 3000 gives second
// 60. The datapath is five register stages, and one item is taken per
// cycle while out_ready stays high. Each stage carries its own valid bit
// and is ready when empty or when the next stage moves, so a stall on the
// result side fills empty stages before in_ready drops. Division by
// constants is done by reciprocal multiplies, with one correction step
// for days, minutes and ticks. Configuration writes take effect at once
// and are meant to be made while the pipeline is empty; writes to unknown
// indexes are ignored and only bit 0 of the data is kept.
module day_count_to_calendar_fields_core
    import dcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] day_count,
    input  logic [15:0] minute_of_day,
    input  logic [15:0] tick_count,
    input  logic [15:0] today_count,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  year_two_digit,
    output logic [3:0]  month_number,
    output logic [4:0]  day_of_month,
    output logic [2:0]  weekday,
    output logic [4:0]  hour_value,
    output logic [5:0]  minute_value,
    output logic [5:0]  second_value,
    output logic        pm_flag,
    output logic [2:0]  relative_class,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic     twelve_hour_reg;
    logic     subst_rel_reg;
    logic     mid_valid, mid_ready;
    dcc_mid_t mid;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twelve_hour_reg <= 1'b0;
            subst_rel_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TWELVE_HOUR: twelve_hour_reg <= cfg_data[0];
                CFG_SUBST_REL:   subst_rel_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Stages 1-3: modular reductions, weekday, relative class
    dcc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .day_count     (day_count),
        .minute_of_day (minute_of_day),
        .tick_count    (tick_count),
        .today_count   (today_count),
        .subst_rel     (subst_rel_reg),
        .mid_valid     (mid_valid),
        .mid_ready     (mid_ready),
        .mid           (mid)
    );

    // Stages 4-5: calendar split, time split, output register
    dcc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mid_valid      (mid_valid),
        .mid_ready      (mid_ready),
        .mid            (mid),
        .twelve_hour    (twelve_hour_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .year_two_digit (year_two_digit),
        .month_number   (month_number),
        .day_of_month   (day_of_month),
        .weekday        (weekday),
        .hour_value     (hour_value),
        .minute_value   (minute_value),
        .second_value   (second_value),
        .pm_flag        (pm_flag),
        .relative_class (relative_class)
    );

endmodule
